// ===== hdl/ccst_pkg.sv =====
`timescale 1ns / 1ps
// ccst_pkg: widths, memory sizes, register indexes and reset values for the
// cyclic-prefix correlation timing block and its port checker
// no dependencies

package ccst_pkg;

    // sample and field widths
    localparam int SAMPLE_W    = 12;
    localparam int FFT_LEN_W   = 12;
    localparam int CP_LEN_W    = 8;
    localparam int SLOT_W      = 14;
    localparam int SEARCH_W    = 17;

    // storage sizes
    localparam int MAX_FFT_LEN = 2048;
    localparam int HIST_DEPTH  = 4096;
    localparam int HIST_AW     = $clog2(HIST_DEPTH);
    localparam int MAX_CP_LEN  = 256;
    localparam int PROD_DEPTH  = MAX_CP_LEN;
    localparam int PROD_AW     = $clog2(PROD_DEPTH);

    // arithmetic widths
    localparam int PROD_W      = 2 * SAMPLE_W + 1;   // one conjugate product
    localparam int SUM_W       = 33;                 // full window of products
    localparam int MAG_W       = SUM_W - 1;          // window magnitude stays below 2^31
    localparam int ENERGY_W    = 2 * MAG_W;
    localparam int SPAN_W      = SEARCH_W + 1;

    // longest usable distance between prefix and copy
    localparam int FFT_CAP_I   = (MAX_FFT_LEN < HIST_DEPTH - 1) ? MAX_FFT_LEN : HIST_DEPTH - 1;
    localparam logic [FFT_LEN_W-1:0] FFT_CAP = FFT_LEN_W'(FFT_CAP_I);

    // positions wrap here when the slot length is zero
    localparam logic [SLOT_W:0] POS_WRAP = (SLOT_W + 1)'(1 << SLOT_W);
    localparam logic [SEARCH_W-1:0] SEEN_MAX = '1;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = SEARCH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FFT_LEN       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CP_LEN        = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LEN      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH = CFG_IDX_W'(3);

    localparam logic [FFT_LEN_W-1:0] FFT_LEN_RST       = FFT_LEN_W'(2048);
    localparam logic [CP_LEN_W-1:0]  CP_LEN_RST        = CP_LEN_W'(144);
    localparam logic [SLOT_W-1:0]    SLOT_LEN_RST      = SLOT_W'(15360);
    localparam logic [SEARCH_W-1:0]  SEARCH_LENGTH_RST = SEARCH_W'(100000);

endpackage

// ===== hdl/cp_correlation_symbol_timing.sv =====
`timescale 1ns / 1ps
// cp_correlation_symbol_timing: cyclic-prefix correlation search over every
// window start, with sample history and product history in block memories
// depends on ccst_pkg
//
//  channel   direction  handshake                  payload
//  --------  ---------  -------------------------  ----------------------------------------
//  sample    in         sample_valid/sample_stall  sample_re, sample_im
//  result    out        result_valid/result_stall  out_re, out_im, symbol_pos, search_done
//  cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
//  the history read happens at the sample transfer edge; after it the sequencer steps
//  through product multiply, window accumulate, two squares on one shared 32x32
//  multiplier, energy add, best compare and result load
//  the next sample is taken once the result register has loaded and the sequencer is back
//  in idle, while that result may still wait to be taken, so one sample at a time
//  a stalled result register holds the sequencer in its last step
//  reset (and a write to fft_len, cp_len or slot_len) clears pointers, fill counts,
//  sums and the best estimate; the memories are not swept, fill counts mark which
//  entries hold real data and the rest read as zero

module cp_correlation_symbol_timing (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    sample_valid,
    output logic                                    sample_stall,
    input  logic signed [ccst_pkg::SAMPLE_W-1:0]    sample_re,
    input  logic signed [ccst_pkg::SAMPLE_W-1:0]    sample_im,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [ccst_pkg::SAMPLE_W-1:0]    out_re,
    output logic signed [ccst_pkg::SAMPLE_W-1:0]    out_im,
    output logic        [ccst_pkg::SLOT_W-1:0]      symbol_pos,
    output logic                                    search_done,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [ccst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic        [ccst_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ccst_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_ADD,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [FFT_LEN_W-1:0] fft_len_reg;
    logic [CP_LEN_W-1:0]  cp_len_reg;
    logic [SLOT_W-1:0]    slot_len_reg;
    logic [SEARCH_W-1:0]  search_length_reg;

    // sample history memory, one complex sample per word
    logic [2*SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
    logic [2*SAMPLE_W-1:0] hist_q_reg;
    logic [HIST_AW-1:0]    hist_wp_reg;
    logic [HIST_AW:0]      hist_fill_reg;
    logic                  hist_ok_reg;

    // product history memory, re and im of one product per word
    logic [2*PROD_W-1:0]   prod_mem [PROD_DEPTH];
    logic [2*PROD_W-1:0]   prod_q_reg;
    logic [PROD_AW-1:0]    prod_wp_reg;
    logic [PROD_AW:0]      prod_fill_reg;
    logic                  prod_ok_reg;

    // per-sample working registers
    logic signed [SAMPLE_W-1:0] in_re_reg;
    logic signed [SAMPLE_W-1:0] in_im_reg;
    logic signed [PROD_W-1:0]   pre_reg;
    logic signed [PROD_W-1:0]   pim_reg;
    logic signed [SUM_W-1:0]    wsum_re_reg;
    logic signed [SUM_W-1:0]    wsum_im_reg;
    logic [ENERGY_W-1:0]        sq_re_reg;
    logic [ENERGY_W-1:0]        sq_im_reg;
    logic [ENERGY_W-1:0]        energy_reg;

    // search state
    logic [ENERGY_W-1:0] best_energy_reg;
    logic [SLOT_W-1:0]   best_pos_reg;
    logic [SEARCH_W-1:0] seen_reg;
    logic [SLOT_W-1:0]   start_phase_reg;   // window start index modulo slot length

    // result register
    logic                       result_valid_reg;
    logic signed [SAMPLE_W-1:0] out_re_reg;
    logic signed [SAMPLE_W-1:0] out_im_reg;
    logic [SLOT_W-1:0]          symbol_pos_reg;
    logic                       search_done_reg;

    // handshakes
    logic sample_fire;
    logic cfg_fire;
    logic restart;
    logic result_free;

    assign cfg_ready    = (state_reg == ST_IDLE);
    // a config write in the same cycle wins, the sample waits
    assign sample_stall = (state_reg != ST_IDLE) || cfg_valid;
    assign sample_fire  = sample_valid && !sample_stall;
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign restart      = cfg_fire && ((cfg_index == CFG_FFT_LEN) ||
                                       (cfg_index == CFG_CP_LEN)  ||
                                       (cfg_index == CFG_SLOT_LEN));
    assign result_free  = !result_valid_reg || !result_stall;

    // effective lengths and read addresses
    logic [FFT_LEN_W-1:0] fft_eff;
    logic [HIST_AW-1:0]   hist_rd_addr;
    logic [PROD_AW-1:0]   prod_rd_addr;
    logic                 hist_hit;
    logic                 prod_hit;
    logic [SLOT_W:0]      slot_eff;

    assign fft_eff      = (fft_len_reg > FFT_CAP) ? FFT_CAP : fft_len_reg;
    assign hist_rd_addr = hist_wp_reg - HIST_AW'(fft_eff);
    assign prod_rd_addr = prod_wp_reg - PROD_AW'(cp_len_reg);
    // the entry fft_len back holds real data once that many samples went in;
    // with a zero distance it is the entry about to be overwritten
    assign hist_hit     = (fft_eff == '0) ? (hist_fill_reg == (HIST_AW + 1)'(HIST_DEPTH))
                                          : ((HIST_AW + 1)'(fft_eff) <= hist_fill_reg);
    assign prod_hit     = (PROD_AW + 1)'(cp_len_reg) <= prod_fill_reg;
    assign slot_eff     = (slot_len_reg == '0) ? POS_WRAP : {1'b0, slot_len_reg};

    // conjugate product old * conj(new)
    logic signed [SAMPLE_W-1:0]   old_re;
    logic signed [SAMPLE_W-1:0]   old_im;
    logic signed [2*SAMPLE_W-1:0] mul_rr;
    logic signed [2*SAMPLE_W-1:0] mul_ii;
    logic signed [2*SAMPLE_W-1:0] mul_ir;
    logic signed [2*SAMPLE_W-1:0] mul_ri;
    logic signed [PROD_W-1:0]     pre_next;
    logic signed [PROD_W-1:0]     pim_next;

    assign old_re   = hist_ok_reg ? signed'(hist_q_reg[2*SAMPLE_W-1:SAMPLE_W]) : '0;
    assign old_im   = hist_ok_reg ? signed'(hist_q_reg[SAMPLE_W-1:0]) : '0;
    assign mul_rr   = old_re * in_re_reg;
    assign mul_ii   = old_im * in_im_reg;
    assign mul_ir   = old_im * in_re_reg;
    assign mul_ri   = old_re * in_im_reg;
    assign pre_next = PROD_W'(mul_rr) + PROD_W'(mul_ii);
    assign pim_next = PROD_W'(mul_ir) - PROD_W'(mul_ri);

    // running window sum: add the new product, drop the one cp_len back
    logic signed [PROD_W-1:0] drop_re;
    logic signed [PROD_W-1:0] drop_im;
    logic signed [SUM_W-1:0]  wsum_re_next;
    logic signed [SUM_W-1:0]  wsum_im_next;

    assign drop_re = prod_ok_reg ? signed'(prod_q_reg[2*PROD_W-1:PROD_W]) : '0;
    assign drop_im = prod_ok_reg ? signed'(prod_q_reg[PROD_W-1:0]) : '0;
    assign wsum_re_next = (cp_len_reg == '0) ? '0
                        : wsum_re_reg + SUM_W'(pre_reg) - SUM_W'(drop_re);
    assign wsum_im_next = (cp_len_reg == '0) ? '0
                        : wsum_im_reg + SUM_W'(pim_reg) - SUM_W'(drop_im);

    // shared squarer for both sum components
    logic signed [SUM_W-1:0] sq_src;
    logic [SUM_W-1:0]        sq_abs;
    logic [MAG_W-1:0]        sq_mag;
    logic [ENERGY_W-1:0]     sq_next;

    assign sq_src  = (state_reg == ST_SQ_RE) ? wsum_re_reg : wsum_im_reg;
    assign sq_abs  = sq_src[SUM_W-1] ? SUM_W'(-sq_src) : SUM_W'(sq_src);
    assign sq_mag  = sq_abs[MAG_W-1:0];
    assign sq_next = ENERGY_W'(sq_mag) * ENERGY_W'(sq_mag);

    // window test for the current sample, t counted before this sample
    logic [SPAN_W-1:0] t_plus1;
    logic [SPAN_W-1:0] span;
    logic              in_window;
    logic              evaluate;
    logic [SLOT_W:0]   phase_inc;
    logic [SLOT_W-1:0] start_phase_next;

    assign t_plus1   = SPAN_W'(seen_reg) + SPAN_W'(1);
    assign span      = SPAN_W'(fft_eff) + SPAN_W'(cp_len_reg);
    assign in_window = t_plus1 >= span;
    assign evaluate  = (cp_len_reg != '0) && (seen_reg < search_length_reg) && in_window;
    assign phase_inc = {1'b0, start_phase_reg} + (SLOT_W + 1)'(1);
    // start index advances once the first full window has been seen
    assign start_phase_next = !in_window ? start_phase_reg
                            : (phase_inc >= slot_eff) ? '0 : phase_inc[SLOT_W-1:0];

    // memories: read data registered, old data returned on a same-address access
    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            hist_q_reg            <= hist_mem[hist_rd_addr];
            hist_mem[hist_wp_reg] <= {sample_re, sample_im};
            prod_q_reg            <= prod_mem[prod_rd_addr];
        end
        if (state_reg == ST_SUM)
        begin
            prod_mem[prod_wp_reg] <= {pre_reg, pim_reg};
        end
    end

    // sequencer, search state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            fft_len_reg       <= FFT_LEN_RST;
            cp_len_reg        <= CP_LEN_RST;
            slot_len_reg      <= SLOT_LEN_RST;
            search_length_reg <= SEARCH_LENGTH_RST;
            hist_wp_reg       <= '0;
            hist_fill_reg     <= '0;
            hist_ok_reg       <= 1'b0;
            prod_wp_reg       <= '0;
            prod_fill_reg     <= '0;
            prod_ok_reg       <= 1'b0;
            in_re_reg         <= '0;
            in_im_reg         <= '0;
            pre_reg           <= '0;
            pim_reg           <= '0;
            wsum_re_reg       <= '0;
            wsum_im_reg       <= '0;
            sq_re_reg         <= '0;
            sq_im_reg         <= '0;
            energy_reg        <= '0;
            best_energy_reg   <= '0;
            best_pos_reg      <= '0;
            seen_reg          <= '0;
            start_phase_reg   <= '0;
            result_valid_reg  <= 1'b0;
            out_re_reg        <= '0;
            out_im_reg        <= '0;
            symbol_pos_reg    <= '0;
            search_done_reg   <= 1'b0;
        end
        else
        begin
            // in the last step the result register is handled by the load below
            if (result_valid_reg && !result_stall && (state_reg != ST_OUT))
            begin
                result_valid_reg <= 1'b0;
            end

            if (cfg_fire)
            begin
                unique case (cfg_index)
                    CFG_FFT_LEN:       fft_len_reg       <= cfg_data[FFT_LEN_W-1:0];
                    CFG_CP_LEN:        cp_len_reg        <= cfg_data[CP_LEN_W-1:0];
                    CFG_SLOT_LEN:      slot_len_reg      <= cfg_data[SLOT_W-1:0];
                    CFG_SEARCH_LENGTH: search_length_reg <= cfg_data[SEARCH_W-1:0];
                    default:           ;
                endcase
            end

            if (restart)
            begin
                hist_wp_reg     <= '0;
                hist_fill_reg   <= '0;
                prod_wp_reg     <= '0;
                prod_fill_reg   <= '0;
                wsum_re_reg     <= '0;
                wsum_im_reg     <= '0;
                best_energy_reg <= '0;
                best_pos_reg    <= '0;
                seen_reg        <= '0;
                start_phase_reg <= '0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_fire)
                    begin
                        in_re_reg   <= sample_re;
                        in_im_reg   <= sample_im;
                        hist_ok_reg <= hist_hit;
                        prod_ok_reg <= prod_hit;
                        hist_wp_reg <= hist_wp_reg + HIST_AW'(1);
                        if (hist_fill_reg != (HIST_AW + 1)'(HIST_DEPTH))
                        begin
                            hist_fill_reg <= hist_fill_reg + (HIST_AW + 1)'(1);
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    pre_reg   <= pre_next;
                    pim_reg   <= pim_next;
                    state_reg <= ST_SUM;
                end
                ST_SUM:
                begin
                    wsum_re_reg <= wsum_re_next;
                    wsum_im_reg <= wsum_im_next;
                    prod_wp_reg <= prod_wp_reg + PROD_AW'(1);
                    if (prod_fill_reg != (PROD_AW + 1)'(PROD_DEPTH))
                    begin
                        prod_fill_reg <= prod_fill_reg + (PROD_AW + 1)'(1);
                    end
                    state_reg <= ST_SQ_RE;
                end
                ST_SQ_RE:
                begin
                    sq_re_reg <= sq_next;
                    state_reg <= ST_SQ_IM;
                end
                ST_SQ_IM:
                begin
                    sq_im_reg <= sq_next;
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    energy_reg <= sq_re_reg + sq_im_reg;
                    state_reg  <= ST_CMP;
                end
                ST_CMP:
                begin
                    // strictly larger only, so the earliest window keeps a tie
                    if (evaluate && (energy_reg > best_energy_reg))
                    begin
                        best_energy_reg <= energy_reg;
                        best_pos_reg    <= start_phase_reg;
                    end
                    start_phase_reg <= start_phase_next;
                    if (seen_reg != SEEN_MAX)
                    begin
                        seen_reg <= seen_reg + SEARCH_W'(1);
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (result_free)
                    begin
                        result_valid_reg <= 1'b1;
                        out_re_reg       <= in_re_reg;
                        out_im_reg       <= in_im_reg;
                        symbol_pos_reg   <= best_pos_reg;
                        search_done_reg  <= (seen_reg >= search_length_reg);
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign out_re       = out_re_reg;
    assign out_im       = out_im_reg;
    assign symbol_pos   = symbol_pos_reg;
    assign search_done  = search_done_reg;

endmodule

// ===== hdl/ccst_checker.sv =====
`timescale 1ns / 1ps
// ccst_checker: port-level checks on the timing search block, bound to the top level
// depends on ccst_pkg and cp_correlation_symbol_timing

module ccst_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    sample_valid,
    input logic                                    sample_stall,
    input logic                                    result_valid,
    input logic                                    result_stall,
    input logic signed [ccst_pkg::SAMPLE_W-1:0]    out_re,
    input logic signed [ccst_pkg::SAMPLE_W-1:0]    out_im,
    input logic        [ccst_pkg::SLOT_W-1:0]      symbol_pos,
    input logic                                    search_done,
    input logic                                    cfg_valid,
    input logic                                    cfg_ready
);
    import ccst_pkg::*;

    // a transferred sample keeps the block busy and the config port closed
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> (sample_stall && !cfg_ready))
        else $error("block took a sample or config write right after a sample");

    // config write and sample transfer never share a cycle
    a_cfg_blocks_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> sample_stall)
        else $error("sample transfer alongside a config write");

    // a result appears only out of the busy sequence
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(sample_stall))
        else $error("result appeared while the block was idle");

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(out_re) &&
            $stable(out_im) && $stable(symbol_pos) && $stable(search_done)))
        else $error("stalled result changed");

endmodule

bind cp_correlation_symbol_timing ccst_checker u_ccst_checker (.*);

// ===== verif/ccst_timing_checker.sv =====
`timescale 1ns / 1ps
// ccst_timing_checker: watches the sample, result and register channels of the
// correlation timing block, tracks the window search and compares every result
// depends on ccst_pkg

module ccst_timing_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   sample_valid,
    input  logic                                   sample_stall,
    input  logic signed [ccst_pkg::SAMPLE_W-1:0]   sample_re,
    input  logic signed [ccst_pkg::SAMPLE_W-1:0]   sample_im,
    input  logic                                   result_valid,
    input  logic                                   result_stall,
    input  logic signed [ccst_pkg::SAMPLE_W-1:0]   out_re,
    input  logic signed [ccst_pkg::SAMPLE_W-1:0]   out_im,
    input  logic        [ccst_pkg::SLOT_W-1:0]     symbol_pos,
    input  logic                                   search_done,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_ready,
    input  logic        [ccst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [ccst_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                     errors,
    output int                                     pending
);
    import ccst_pkg::*;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] re;
        logic signed [SAMPLE_W-1:0] im;
        logic        [SLOT_W-1:0]   pos;
        logic                       done;
    } timing_out_t;

    // register copies
    int unsigned fft_reg, cp_reg, slot_reg, search_reg;

    // search state
    logic signed [SAMPLE_W-1:0] hist_re [HIST_DEPTH];
    logic signed [SAMPLE_W-1:0] hist_im [HIST_DEPTH];
    longint                     prod_re [PROD_DEPTH];
    longint                     prod_im [PROD_DEPTH];
    int unsigned                hist_wr, prod_wr;
    longint                     win_re, win_im;
    longint unsigned            best_energy;
    int unsigned                best_at, seen, slot_phase;

    timing_out_t predicted_outputs [$];
    int          mismatches = 0;
    int          result_count = 0;

    assign errors  = mismatches;
    assign pending = predicted_outputs.size();

    function automatic void clear_search();
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            hist_re[k] = '0;
            hist_im[k] = '0;
        end
        for (int k = 0; k < PROD_DEPTH; k++)
        begin
            prod_re[k] = 0;
            prod_im[k] = 0;
        end
        hist_wr     = 0;
        prod_wr     = 0;
        win_re      = 0;
        win_im      = 0;
        best_energy = 0;
        best_at     = 0;
        seen        = 0;
        slot_phase  = 0;
    endfunction

    // one sample through the correlator: returns what the block should emit
    function automatic timing_out_t track_correlation(input logic signed [SAMPLE_W-1:0] s_re,
                                                      input logic signed [SAMPLE_W-1:0] s_im);
        int unsigned     f, c, wrap, oi, li, back;
        int              ore, oim, nre, nim;
        longint          pre, pim;
        longint unsigned mre, mim, energy;
        timing_out_t     r;

        f    = (fft_reg > FFT_CAP_I) ? FFT_CAP_I : fft_reg;
        c    = (cp_reg > MAX_CP_LEN) ? MAX_CP_LEN : cp_reg;
        wrap = (slot_reg != 0) ? slot_reg : int'(POS_WRAP);
        nre  = s_re;
        nim  = s_im;

        // older sample of the pair, fft_len places back
        oi  = (hist_wr + HIST_DEPTH - f) % HIST_DEPTH;
        ore = hist_re[oi];
        oim = hist_im[oi];
        hist_re[hist_wr] = s_re;
        hist_im[hist_wr] = s_im;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;

        pre = longint'(ore) * nre + longint'(oim) * nim;
        pim = longint'(oim) * nre - longint'(ore) * nim;
        li  = (prod_wr + PROD_DEPTH - c) % PROD_DEPTH;
        if (c == 0)
        begin
            win_re = 0;
            win_im = 0;
        end
        else
        begin
            win_re += pre - prod_re[li];
            win_im += pim - prod_im[li];
        end
        prod_re[prod_wr] = pre;
        prod_im[prod_wr] = pim;
        prod_wr = (prod_wr + 1) % PROD_DEPTH;

        // strictly larger energy wins, so ties keep the earliest window
        if (c != 0 && seen < search_reg && seen + 1 >= f + c)
        begin
            mre    = (win_re < 0) ? -win_re : win_re;
            mim    = (win_im < 0) ? -win_im : win_im;
            energy = mre * mre + mim * mim;
            if (energy > best_energy)
            begin
                back        = (f + c - 1) % wrap;
                best_energy = energy;
                best_at     = (slot_phase + wrap - back) % wrap;
            end
        end

        slot_phase = (slot_phase + 1 >= wrap) ? 0 : slot_phase + 1;
        if (seen < int'(SEEN_MAX))
            seen++;

        r.re   = s_re;
        r.im   = s_im;
        r.pos  = best_at[SLOT_W-1:0];
        r.done = (seen >= search_reg);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        timing_out_t want, got;
        if (!rst_n)
        begin
            fft_reg    = FFT_LEN_RST;
            cp_reg     = CP_LEN_RST;
            slot_reg   = SLOT_LEN_RST;
            search_reg = SEARCH_LENGTH_RST;
            clear_search();
            predicted_outputs.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FFT_LEN:
                    begin
                        fft_reg = cfg_data[FFT_LEN_W-1:0];
                        clear_search();
                    end
                    CFG_CP_LEN:
                    begin
                        cp_reg = cfg_data[CP_LEN_W-1:0];
                        clear_search();
                    end
                    CFG_SLOT_LEN:
                    begin
                        slot_reg = cfg_data[SLOT_W-1:0];
                        clear_search();
                    end
                    CFG_SEARCH_LENGTH: search_reg = cfg_data[SEARCH_W-1:0];
                    default: ;
                endcase
            end

            if (sample_valid && !sample_stall)
                predicted_outputs.push_back(track_correlation(sample_re, sample_im));

            if (result_valid && !result_stall)
            begin
                got = '{re: out_re, im: out_im, pos: symbol_pos, done: search_done};
                if (predicted_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d arrived with no sample behind it", result_count);
                end
                else
                begin
                    want = predicted_outputs.pop_front();
                    if (want != got)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result %0d exp/got: re %0d/%0d im %0d/%0d pos %0d/%0d done %0b/%0b",
                                     result_count, want.re, got.re, want.im, got.im,
                                     want.pos, got.pos, want.done, got.done);
                    end
                end
                result_count++;
            end
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: drives samples and register writes into the correlation timing block and
// gives the verdict; prediction and comparison live in ccst_timing_checker
// depends on ccst_pkg, cp_correlation_symbol_timing, ccst_timing_checker

module tb;
    import ccst_pkg::*;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 12'sh7FF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 12'sh800;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         sample_valid = 1'b0;
    logic                         sample_stall;
    logic signed [SAMPLE_W-1:0]   sample_re = '0;
    logic signed [SAMPLE_W-1:0]   sample_im = '0;
    logic                         result_valid;
    logic                         result_stall = 1'b0;
    logic signed [SAMPLE_W-1:0]   out_re;
    logic signed [SAMPLE_W-1:0]   out_im;
    logic        [SLOT_W-1:0]     symbol_pos;
    logic                         search_done;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index = '0;
    logic        [CFG_DATA_W-1:0] cfg_data = '0;
    int                           errors;
    int                           pending;

    // idle odds in percent: sender gaps and receiver stalls
    int send_gap_pct = 6;
    int stall_pct    = 61;

    cp_correlation_symbol_timing dut (.*);

    ccst_timing_checker checker_i (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver stalls are drawn fresh every cycle
    always @(negedge clk)
        result_stall <= ($urandom_range(0, 99) < stall_pct);

    // one sample transfer; entered and left at a falling edge, valid stays up
    // between back-to-back samples so there is never a drop and re-raise
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s_re,
                               input logic signed [SAMPLE_W-1:0] s_im);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_re    <= s_re;
        sample_im    <= s_im;
        do
            @(posedge clk);
        while (sample_stall);
        @(negedge clk);
    endtask

    // register write; caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // hold the sample channel quiet until every result is back
    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // mostly ofdm-like symbols: a body of fft samples led by a copy of its
    // tail, which is what the correlator locks onto; the rest is noise bursts
    // and symbols whose prefix is garbage
    task automatic stream(input int n, input int fft, input int cp);
        logic signed [SAMPLE_W-1:0] body_re [MAX_FFT_LEN];
        logic signed [SAMPLE_W-1:0] body_im [MAX_FFT_LEN];
        int sent, kind, span, lead, amp, burst;
        sent = 0;
        span = (fft > MAX_FFT_LEN) ? MAX_FFT_LEN : ((fft == 0) ? 16 : fft);
        lead = (cp > span) ? span : cp;
        while (sent < n)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 7 || kind == 8)
            begin
                // full-range noise, reaches every bit pattern
                burst = $urandom_range(1, lead + 8);
                for (int k = 0; k < burst && sent < n; k++)
                begin
                    send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    sent++;
                end
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       amp = 2047;
                    1:       amp = 300;
                    default: amp = 20;
                endcase
                for (int k = 0; k < span; k++)
                begin
                    body_re[k] = SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
                    body_im[k] = SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
                end
                // prefix, garbled on a broken symbol
                for (int k = span - lead; k < span && sent < n; k++)
                begin
                    if (kind == 9)
                        send_sample(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    else
                        send_sample(body_re[k], body_im[k]);
                    sent++;
                end
                for (int k = 0; k < span && sent < n; k++)
                begin
                    send_sample(body_re[k], body_im[k]);
                    sent++;
                end
            end
        end
    endtask

    // new settings on an idle block, then a stretch of samples under them
    task automatic run_phase(input logic [CFG_DATA_W-1:0] fft,
                             input logic [CFG_DATA_W-1:0] cp,
                             input logic [CFG_DATA_W-1:0] slot,
                             input logic [CFG_DATA_W-1:0] srch,
                             input int n);
        wait_idle();
        write_reg(CFG_FFT_LEN, fft);
        write_reg(CFG_CP_LEN, cp);
        write_reg(CFG_SLOT_LEN, slot);
        write_reg(CFG_SEARCH_LENGTH, srch);
        cfg_valid <= 1'b0;
        stream(n, int'(fft[FFT_LEN_W-1:0]), int'(cp[CP_LEN_W-1:0]));
    endtask

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: plain pass-through, search still far from its first window
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample('0, '0);
        send_sample(-12'sd1, -12'sd1);

        // tiny settings so the directed samples reach the search
        wait_idle();
        write_reg(CFG_FFT_LEN, 17'd4);
        write_reg(CFG_CP_LEN, 17'd2);
        write_reg(CFG_SLOT_LEN, 17'd5);
        write_reg(CFG_SEARCH_LENGTH, 17'd40);
        cfg_valid <= 1'b0;

        // field extremes, largest products of both signs
        send_sample(S_MIN, S_MIN);
        send_sample(S_MAX, S_MAX);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample(12'sd1, -12'sd1);
        send_sample(-12'sd1, 12'sd1);
        // constant run: every full window wholly inside the run has the same energy, earliest must stay
        for (int k = 0; k < 10; k++)
            send_sample(12'sd300, -12'sd300);
        // one short symbol with its prefix
        send_sample(12'sd77, -12'sd500);
        send_sample(-12'sd9, 12'sd1200);
        send_sample(12'sd640, 12'sd3);
        send_sample(-12'sd1800, -12'sd45);
        send_sample(12'sd77, -12'sd500);
        send_sample(-12'sd9, 12'sd1200);

        // sender seldom idle, receiver stalls a lot
        send_gap_pct = 6;
        stall_pct    = 61;
        run_phase(17'd16, 17'd4, 17'd960, 17'd131071, 120);
        // pause mid-stream until the block has drained, state carries on
        wait_idle();
        stream(120, 16, 4);
        // junk above each register's width must be dropped
        run_phase(17'h1F080, 17'h12309, 17'h1C001, 17'd300, 260);
        // search_length and unknown indexes leave the search state alone
        wait_idle();
        write_reg(CFG_IDX_W'(4), 17'h1FFFF);
        write_reg(CFG_IDX_W'(15), 17'd0);
        write_reg(CFG_SEARCH_LENGTH, 17'd0);
        cfg_valid <= 1'b0;
        stream(60, 128, 9);

        // sender idles a lot, receiver seldom stalls
        send_gap_pct = 61;
        stall_pct    = 6;
        // shortest lengths, zero slot length wraps positions at 16384
        run_phase(17'd1, 17'd1, 17'd0, 17'd200, 150);
        // zero fft length pairs each sample with the one a full history back
        run_phase(17'd0, 17'd3, 17'd16383, 17'd5000, 150);
        // zero cp length: the window sum is stuck at zero
        run_phase(17'd32, 17'd0, 17'd7, 17'd1000, 100);

        // no idling on either side
        send_gap_pct = 0;
        stall_pct    = 0;
        run_phase(17'd64, 17'd255, 17'd15360, 17'd1000, 340);
        // fft length beyond the largest symbol, short run with the history still empty
        run_phase(17'd4095, 17'd8, 17'd100, 17'd131071, 40);
        // search freezes almost at once
        run_phase(17'd8, 17'd2, 17'd13, 17'd2, 40);

        wait_idle();
        // let any stray result show up before the verdict
        repeat (20) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #10000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ccst_pkg.sv
hdl/cp_correlation_symbol_timing.sv
hdl/ccst_checker.sv
verif/ccst_timing_checker.sv
verif/tb.sv
